// ===== rtl/bole_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_pkg: shared types for the bounded ordered list engine
// command and result words, status codes and cell control
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int unsigned ListDepthDef = 32;
  localparam int unsigned ValW         = 32;
  localparam int unsigned PosW         = 6;
  // wide enough for a position, the count and the count at full depth
  localparam int unsigned CmpW         = PosW + 1;

  typedef enum logic [3:0] {
    FN_INS_FRONT = 4'd0,
    FN_INS_END   = 4'd1,
    FN_INS_POS   = 4'd2,
    FN_DEL_FRONT = 4'd3,
    FN_DEL_END   = 4'd4,
    FN_DEL_POS   = 4'd5,
    FN_SEARCH    = 4'd6,
    FN_READ_FWD  = 4'd7,
    FN_READ_BACK = 4'd8
  } func_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_EMPTY    = 3'd1,
    STS_BADPOS   = 3'd2,
    STS_FULL     = 3'd3,
    STS_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    func_e                  func;
    logic signed [ValW-1:0] value;
    logic [PosW-1:0]        position;
  } cmd_t;

  typedef struct packed {
    status_e                status;
    logic [PosW-1:0]        found_index;
    logic signed [ValW-1:0] entry_value;
    logic                   last;
  } res_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROTL,
    OP_ROTR
  } cell_op_e;

  typedef struct packed {
    cell_op_e               op;
    logic [CmpW-1:0]        pos;
    logic [CmpW-1:0]        cnt;
    logic [CmpW-1:0]        last_idx;
    logic signed [ValW-1:0] value;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ
  } state_e;

endpackage

// ===== rtl/bole_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_cell: one list slot
// holds one entry, shifts for insert and delete, rotates for readout
// ----------------------------------------------------------------------------
module bole_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                            clk_i,
  input  bole_pkg::cell_ctrl_t            ctrl_i,
  input  logic signed [bole_pkg::ValW-1:0] left_i,
  input  logic signed [bole_pkg::ValW-1:0] right_i,
  input  logic signed [bole_pkg::ValW-1:0] head_i,
  input  logic signed [bole_pkg::ValW-1:0] tail_i,
  output logic signed [bole_pkg::ValW-1:0] val_o,
  output logic                            match_o
);
  import bole_pkg::*;

  localparam logic [CmpW-1:0] IdxC = CmpW'(IDX);

  logic signed [ValW-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    unique case (ctrl_i.op)
      OP_HOLD: val_d = val_q;
      OP_INS: begin
        if (IdxC > ctrl_i.pos) begin
          val_d = left_i;
        end else if (IdxC == ctrl_i.pos) begin
          val_d = ctrl_i.value;
        end
      end
      OP_DEL: begin
        if (IdxC >= ctrl_i.pos) begin
          val_d = right_i;
        end
      end
      // front leaves at the head, wraps in at the tail slot
      OP_ROTL: val_d = (IdxC == ctrl_i.last_idx) ? head_i : right_i;
      OP_ROTR: val_d = (IdxC == '0) ? tail_i : left_i;
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign match_o = (val_q == ctrl_i.value) && (IdxC < ctrl_i.cnt);

endmodule

// ===== rtl/bounded_ordered_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine: positional list of signed words in a cell row
// insert and delete: result word the cycle after start, busy stays low
// search: compare in every cell (registered), then first-match encode, busy 1 cycle
// readout: one word per cycle from the head or tail cell while
//   the row rotates; busy until the last word, receiver cannot stall
// reset: rst_ni async low clears count and control; cell contents are not reset
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine #(
  parameter int unsigned LIST_DEPTH = bole_pkg::ListDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bole_pkg::cmd_t cmd_i,
  output logic           result_valid_o,
  output bole_pkg::res_t result_o
);
  import bole_pkg::*;

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(LIST_DEPTH);
  localparam logic [CmpW-1:0] DepthC = CmpW'(LIST_DEPTH);

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   rd_cnt_q, rd_cnt_d;
  logic              rd_back_q, rd_back_d;
  logic [LIST_DEPTH-1:0] match_q;
  logic [LIST_DEPTH-1:0] match_w;
  res_t              result_q, result_d;
  logic              valid_q, valid_d;

  cell_ctrl_t        ctrl;
  logic signed [ValW-1:0] cell_val [LIST_DEPTH];
  logic signed [ValW-1:0] head_val, tail_val;

  logic              accept;
  logic [CmpW-1:0]   cnt_ext, last_idx, pos_ext;
  logic              rd_last;
  logic              hit;
  logic [PosW-1:0]   hit_idx;

  assign accept   = start && !busy;
  assign busy     = (state_q != ST_IDLE);
  assign cnt_ext  = CmpW'(count_q);
  assign last_idx = cnt_ext - CmpW'(1);
  assign pos_ext  = CmpW'(cmd_i.position);
  assign rd_last  = (CmpW'(rd_cnt_q) == last_idx);

  // head and tail of the live part of the row
  assign head_val = cell_val[0];
  assign tail_val = cell_val[last_idx[IdxW-1:0]];

  // row of cells
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [ValW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_val[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_val[i+1];
    end
    bole_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (head_val),
      .tail_i  (tail_val),
      .val_o   (cell_val[i]),
      .match_o (match_w[i])
    );
  end

  // first match over the registered compare vector
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = LIST_DEPTH - 1; k >= 0; k--) begin
      if (match_q[k]) begin
        hit     = 1'b1;
        hit_idx = PosW'(k);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i.func == FN_SEARCH) begin
            state_d = ST_SEARCH;
          end else if ((cmd_i.func == FN_READ_FWD || cmd_i.func == FN_READ_BACK)
                       && count_q != '0) begin
            state_d = ST_READ;
          end
        end
      end
      ST_SEARCH: state_d = ST_IDLE;
      ST_READ:   state_d = rd_last ? ST_IDLE : ST_READ;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath control and result word
  always_comb begin
    ctrl          = '0;
    ctrl.op       = OP_HOLD;
    ctrl.cnt      = cnt_ext;
    ctrl.last_idx = last_idx;
    ctrl.value    = cmd_i.value;
    count_d       = count_q;
    rd_cnt_d      = rd_cnt_q;
    rd_back_d     = rd_back_q;
    valid_d       = 1'b0;
    result_d      = '0;
    result_d.status = STS_OK;
    result_d.last = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          valid_d = 1'b1;
          unique case (cmd_i.func)
            FN_INS_FRONT, FN_INS_END, FN_INS_POS: begin
              if (cmd_i.func == FN_INS_FRONT) begin
                ctrl.pos = '0;
              end else if (cmd_i.func == FN_INS_END) begin
                ctrl.pos = cnt_ext;
              end else begin
                ctrl.pos = pos_ext;
              end
              // position check before capacity check
              if (ctrl.pos > cnt_ext) begin
                result_d.status = STS_BADPOS;
              end else if (cnt_ext == DepthC) begin
                result_d.status = STS_FULL;
              end else begin
                ctrl.op = OP_INS;
                count_d = count_q + CntW'(1);
              end
            end
            FN_DEL_FRONT, FN_DEL_END, FN_DEL_POS: begin
              if (cmd_i.func == FN_DEL_FRONT) begin
                ctrl.pos = '0;
              end else if (cmd_i.func == FN_DEL_END) begin
                ctrl.pos = last_idx;
              end else begin
                ctrl.pos = pos_ext;
              end
              if (count_q == '0) begin
                result_d.status = STS_EMPTY;
              end else if (ctrl.pos >= cnt_ext) begin
                result_d.status = STS_BADPOS;
              end else begin
                ctrl.op = OP_DEL;
                count_d = count_q - CntW'(1);
              end
            end
            FN_SEARCH: begin
              // compare vector is captured now; the search state encodes and answers
              valid_d = 1'b0;
            end
            FN_READ_FWD, FN_READ_BACK: begin
              if (count_q == '0) begin
                result_d.status = STS_EMPTY;
              end else begin
                valid_d   = 1'b0;
                rd_cnt_d  = '0;
                rd_back_d = (cmd_i.func == FN_READ_BACK);
              end
            end
            default: begin
              // unused codes: plain ok word
              result_d.status = STS_OK;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        valid_d = 1'b1;
        if (hit) begin
          result_d.found_index = hit_idx;
        end else begin
          result_d.status = STS_NOTFOUND;
        end
      end
      ST_READ: begin
        // emit the end cell, then rotate so the next entry takes its place
        valid_d              = 1'b1;
        ctrl.op              = rd_back_q ? OP_ROTR : OP_ROTL;
        result_d.entry_value = rd_back_q ? tail_val : head_val;
        result_d.last        = rd_last;
        rd_cnt_d             = rd_cnt_q + CntW'(1);
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_cnt_q  <= '0;
      rd_back_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_back_q <= rd_back_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    if (accept) begin
      match_q <= match_w;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule
